// ===== rtl/core/bpd_pkg.sv =====
// bpd_pkg: shared types and constants of the beam peak detector
// no dependencies; imported by bpd_track, bpd_out_buf and beam_peak_detector
`timescale 1ns / 1ps

package bpd_pkg;

  localparam int unsigned LevelW = 16;
  localparam int unsigned BinW   = 12;
  localparam int unsigned FracW  = 11;
  localparam int unsigned FracSh = 10;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  // valley level register is one bit wider than a sample so it can hold the marker
  localparam logic [LevelW:0] NoValley = 17'd99999;
  localparam logic [BinW-1:0] BinMax   = 12'd4095;

  localparam logic [CfgIdxW-1:0] RegMinPeakHeight    = 2'd0;
  localparam logic [CfgIdxW-1:0] RegEndFraction      = 2'd1;
  localparam logic [CfgIdxW-1:0] RegRecursiveFraction = 2'd2;

  localparam logic [FracW-1:0]  RstEndFraction       = 11'd614;
  localparam logic [FracW-1:0]  RstRecursiveFraction = 11'd1004;
  localparam logic [LevelW-1:0] RstMinPeakHeight     = 16'd110;

  typedef struct packed {
    logic [LevelW-1:0] min_peak_height;
    logic [FracW-1:0]  end_fraction;
    logic [FracW-1:0]  recursive_fraction;
  } bpd_cfg_t;

  typedef struct packed {
    logic [BinW-1:0]   valley_bin;
    logic [BinW-1:0]   peak_bin;
    logic [BinW-1:0]   end_bin;
    logic [LevelW-1:0] valley_level;
    logic [LevelW-1:0] peak_level;
    logic [LevelW-1:0] threshold;
  } bpd_result_t;

endpackage

// ===== rtl/core/bpd_track.sv =====
// bpd_track: valley / peak tracking state and the per-sample close decision
// depends on bpd_pkg
`timescale 1ns / 1ps

module bpd_track #(
  parameter int unsigned MAX_BINS = 4096
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      accept_i,
  input  logic [bpd_pkg::LevelW-1:0] intensity_i,
  input  logic                      visited_i,
  input  logic                      beam_start_i,
  input  bpd_pkg::bpd_cfg_t         cfg_i,
  output logic                      res_valid_o,
  output bpd_pkg::bpd_result_t      res_o
);
  import bpd_pkg::*;

  localparam int unsigned LimitInt = (MAX_BINS - 1 > 4095) ? 4095 : (MAX_BINS - 1);
  localparam logic [BinW-1:0] BinLimit = BinW'(LimitInt);
  localparam int unsigned ProdW = LevelW + FracW;

  logic [LevelW:0]   valley_q, valley_d;
  logic [BinW-1:0]   valley_idx_q, valley_idx_d;
  logic [LevelW-1:0] peak_q, peak_d;
  logic [BinW-1:0]   peak_idx_q, peak_idx_d;
  logic [BinW-1:0]   bin_q, bin_d;

  logic [LevelW:0]   cur_valley;
  logic [LevelW-1:0] cur_peak;
  logic [BinW-1:0]   idx;
  logic [LevelW-1:0] height;
  logic [LevelW-1:0] rise;
  logic [ProdW-1:0]  end_prod;
  logic [ProdW-1:0]  rise_scaled;
  logic [ProdW-1:0]  thr_prod;
  logic [LevelW+1:0] thr_sum;
  logic [LevelW-1:0] thr;
  logic              closes;

  always_comb begin
    cur_valley = beam_start_i ? NoValley : valley_q;
    cur_peak   = beam_start_i ? '0 : peak_q;
    idx        = beam_start_i ? '0 : bin_q;

    // only meaningful when peak > valley, where valley fits in a sample
    height      = cur_peak - cur_valley[LevelW-1:0];
    rise        = intensity_i - cur_valley[LevelW-1:0];
    end_prod    = {{FracW{1'b0}}, height} * {{LevelW{1'b0}}, cfg_i.end_fraction};
    rise_scaled = {1'b0, rise, {FracSh{1'b0}}};
    closes      = rise_scaled < end_prod;

    thr_prod = {{FracW{1'b0}}, height} * {{LevelW{1'b0}}, cfg_i.recursive_fraction};
    thr_sum  = {2'b00, cur_valley[LevelW-1:0]} + {1'b0, thr_prod[ProdW-1:FracSh]};
    thr      = (thr_sum[LevelW+1:LevelW] != 2'b00) ? {LevelW{1'b1}} : thr_sum[LevelW-1:0];

    valley_d     = cur_valley;
    valley_idx_d = valley_idx_q;
    peak_d       = cur_peak;
    peak_idx_d   = peak_idx_q;
    res_valid_o  = 1'b0;

    if (visited_i) begin
      valley_d = NoValley;
      peak_d   = '0;
    end else if ({1'b0, intensity_i} < cur_valley) begin
      valley_d     = {1'b0, intensity_i};
      valley_idx_d = idx;
      peak_d       = '0;
    end else if (intensity_i > cur_peak) begin
      peak_d     = intensity_i;
      peak_idx_d = idx;
    end else if ({1'b0, cur_peak} > cur_valley && closes) begin
      res_valid_o  = accept_i && (height > cfg_i.min_peak_height);
      valley_d     = {1'b0, intensity_i};
      valley_idx_d = idx;
      peak_d       = '0;
    end

    bin_d = (idx < BinLimit) ? idx + 1'b1 : idx;

    res_o.valley_bin   = valley_idx_q;
    res_o.peak_bin     = peak_idx_q;
    res_o.end_bin      = idx;
    res_o.valley_level = cur_valley[LevelW-1:0];
    res_o.peak_level   = cur_peak;
    res_o.threshold    = thr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valley_q     <= NoValley;
      valley_idx_q <= '0;
      peak_q       <= '0;
      peak_idx_q   <= '0;
      bin_q        <= '0;
    end else if (accept_i) begin
      valley_q     <= valley_d;
      valley_idx_q <= valley_idx_d;
      peak_q       <= peak_d;
      peak_idx_q   <= peak_idx_d;
      bin_q        <= bin_d;
    end
  end

endmodule

// ===== rtl/core/bpd_out_buf.sv =====
// bpd_out_buf: output register with a skid entry for the result channel
// depends on bpd_pkg
`timescale 1ns / 1ps

module bpd_out_buf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  bpd_pkg::bpd_result_t push_data_i,
  output logic                 space_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output bpd_pkg::bpd_result_t out_data_o
);
  import bpd_pkg::*;

  logic        out_valid_q, out_valid_d;
  logic        skid_valid_q, skid_valid_d;
  bpd_result_t out_q, out_d;
  bpd_result_t skid_q, skid_d;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (!out_valid_q || out_ready_i) begin
      // output slot frees up: the older skid entry goes first
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = push_i;
        skid_d       = push_data_i;
      end else begin
        out_valid_d = push_i;
        out_d       = push_data_i;
      end
    end else if (push_i) begin
      skid_valid_d = 1'b1;
      skid_d       = push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign space_o     = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/core/beam_peak_detector.sv =====
// beam_peak_detector: one sample per cycle while the skid entry is free, state updated at the input transfer
// a closed peak is registered in the output register, or in the skid entry while the output is stalled
// throughput: one sample per cycle while the skid entry is free, set by the tracking update
// a two-entry output buffer keeps input transfers going while a result is stalled, until the skid entry fills
// reset: tracking cleared (no valley), bin index zero, registers at their defaults
`timescale 1ns / 1ps

module beam_peak_detector #(
  parameter int unsigned MAX_BINS = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bpd_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [bpd_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [bpd_pkg::LevelW-1:0]    intensity_i,
  input  logic                          visited_i,
  input  logic                          beam_start_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [bpd_pkg::BinW-1:0]      valley_bin_o,
  output logic [bpd_pkg::BinW-1:0]      peak_bin_o,
  output logic [bpd_pkg::BinW-1:0]      end_bin_o,
  output logic [bpd_pkg::LevelW-1:0]    valley_level_o,
  output logic [bpd_pkg::LevelW-1:0]    peak_level_o,
  output logic [bpd_pkg::LevelW-1:0]    threshold_o
);
  import bpd_pkg::*;

  bpd_cfg_t    cfg_q;
  logic        accept;
  logic        res_valid;
  logic        space;
  bpd_result_t res;
  bpd_result_t out_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_peak_height    <= RstMinPeakHeight;
      cfg_q.end_fraction       <= RstEndFraction;
      cfg_q.recursive_fraction <= RstRecursiveFraction;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegMinPeakHeight:     cfg_q.min_peak_height    <= cfg_data_i;
        RegEndFraction:       cfg_q.end_fraction       <= cfg_data_i[FracW-1:0];
        RegRecursiveFraction: cfg_q.recursive_fraction <= cfg_data_i[FracW-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready_o = space;
  assign accept     = in_valid_i && space;

  bpd_track #(
    .MAX_BINS(MAX_BINS)
  ) u_track (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .intensity_i (intensity_i),
    .visited_i   (visited_i),
    .beam_start_i(beam_start_i),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  bpd_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (res_valid),
    .push_data_i(res),
    .space_o    (space),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data)
  );

  assign valley_bin_o   = out_data.valley_bin;
  assign peak_bin_o     = out_data.peak_bin;
  assign end_bin_o      = out_data.end_bin;
  assign valley_level_o = out_data.valley_level;
  assign peak_level_o   = out_data.peak_level;
  assign threshold_o    = out_data.threshold;

endmodule

// ===== tb/beam_peak_detector_chk.sv =====
// beam_peak_detector_chk: watches the sample, result and register ports of the detector
// tracks valley and peak per beam and compares each result transfer; needs bpd_pkg
`timescale 1ns / 1ps

module beam_peak_detector_chk #(
  parameter int unsigned BinLimit = 4095
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bpd_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [bpd_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [bpd_pkg::LevelW-1:0]    intensity_i,
  input  logic                          visited_i,
  input  logic                          beam_start_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [bpd_pkg::BinW-1:0]      valley_bin_i,
  input  logic [bpd_pkg::BinW-1:0]      peak_bin_i,
  input  logic [bpd_pkg::BinW-1:0]      end_bin_i,
  input  logic [bpd_pkg::LevelW-1:0]    valley_level_i,
  input  logic [bpd_pkg::LevelW-1:0]    peak_level_i,
  input  logic [bpd_pkg::LevelW-1:0]    threshold_i,
  output int unsigned                   mismatches_o,
  output int unsigned                   peaks_pending_o
);

  import bpd_pkg::*;

  bpd_cfg_t          cfg;
  logic [LevelW:0]   valley_lvl;
  logic [BinW-1:0]   valley_at;
  logic [LevelW-1:0] peak_lvl;
  logic [BinW-1:0]   peak_at;
  logic [BinW-1:0]   bin_now;
  bpd_result_t       peaks_due[$];

  task automatic track_sample(input logic [LevelW-1:0] lvl, input logic vis, input logic bs);
    logic [31:0] height;
    logic [31:0] rise;
    logic [31:0] thr;
    bpd_result_t peak;
    if (bs) begin
      bin_now    = '0;
      valley_lvl = NoValley;
      peak_lvl   = '0;
    end
    if (vis) begin
      valley_lvl = NoValley;
      peak_lvl   = '0;
    end else if ({1'b0, lvl} < valley_lvl) begin
      valley_lvl = {1'b0, lvl};
      valley_at  = bin_now;
      peak_lvl   = '0;
    end else if (lvl > peak_lvl) begin
      peak_lvl = lvl;
      peak_at  = bin_now;
    end else if ({1'b0, peak_lvl} > valley_lvl) begin
      height = 32'(peak_lvl) - 32'(valley_lvl);
      rise   = 32'(lvl) - 32'(valley_lvl);
      // exact close test, fractions above one included
      if ((rise << FracSh) < height * 32'(cfg.end_fraction)) begin
        if (height > 32'(cfg.min_peak_height)) begin
          thr = 32'(valley_lvl) + ((height * 32'(cfg.recursive_fraction)) >> FracSh);
          if (thr > 32'hFFFF) thr = 32'hFFFF;
          peak.valley_bin   = valley_at;
          peak.peak_bin     = peak_at;
          peak.end_bin      = bin_now;
          peak.valley_level = valley_lvl[LevelW-1:0];
          peak.peak_level   = peak_lvl;
          peak.threshold    = thr[LevelW-1:0];
          peaks_due = {peaks_due, peak};
        end
        valley_lvl = {1'b0, lvl};
        valley_at  = bin_now;
        peak_lvl   = '0;
      end
    end
    if (bin_now < BinLimit) bin_now++;
  endtask

  task automatic check_field(input string name, input logic [LevelW-1:0] want,
                             input logic [LevelW-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches_o++;
    end
  endtask

  task automatic check_peak();
    bpd_result_t want;
    if (peaks_due.size() == 0) begin
      $error("result transfer with no peak expected");
      mismatches_o++;
    end else begin
      want = peaks_due.pop_front();
      check_field("valley_bin", 16'(want.valley_bin), 16'(valley_bin_i));
      check_field("peak_bin", 16'(want.peak_bin), 16'(peak_bin_i));
      check_field("end_bin", 16'(want.end_bin), 16'(end_bin_i));
      check_field("valley_level", want.valley_level, valley_level_i);
      check_field("peak_level", want.peak_level, peak_level_i);
      check_field("threshold", want.threshold, threshold_i);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg.min_peak_height    = RstMinPeakHeight;
      cfg.end_fraction       = RstEndFraction;
      cfg.recursive_fraction = RstRecursiveFraction;
      valley_lvl      = NoValley;
      valley_at       = '0;
      peak_lvl        = '0;
      peak_at         = '0;
      bin_now         = '0;
      peaks_due.delete();
      mismatches_o    = 0;
      peaks_pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegMinPeakHeight:     cfg.min_peak_height    = cfg_data_i;
          RegEndFraction:       cfg.end_fraction       = cfg_data_i[FracW-1:0];
          RegRecursiveFraction: cfg.recursive_fraction = cfg_data_i[FracW-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) check_peak();
      if (in_valid_i && in_ready_i) track_sample(intensity_i, visited_i, beam_start_i);
      peaks_pending_o = peaks_due.size();
    end
  end

endmodule

// ===== tb/beam_peak_detector_tb.sv =====
// beam_peak_detector_tb: drives beams of samples and register settings into the detector
// uses bpd_pkg, beam_peak_detector and beam_peak_detector_chk for the comparison
`timescale 1ns / 1ps

module beam_peak_detector_tb;

  import bpd_pkg::*;

  localparam int unsigned MaxBins      = 4096;
  localparam int unsigned BinLimit     = (MaxBins - 1 > 4095) ? 4095 : MaxBins - 1;
  localparam int unsigned StallLimit   = 2000;
  localparam int unsigned HoldCycles   = 150;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned PhaseCount   = 7;
  localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [LevelW-1:0]   intensity_i;
  logic                visited_i;
  logic                beam_start_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [BinW-1:0]     valley_bin_o;
  logic [BinW-1:0]     peak_bin_o;
  logic [BinW-1:0]     end_bin_o;
  logic [LevelW-1:0]   valley_level_o;
  logic [LevelW-1:0]   peak_level_o;
  logic [LevelW-1:0]   threshold_o;

  int unsigned mismatches;
  int unsigned peaks_pending;
  int unsigned samples_sent = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned cur_mph = RstMinPeakHeight;
  int unsigned cur_ef = RstEndFraction;
  bit          hold_req = 1'b0;

  beam_peak_detector #(
    .MAX_BINS (MaxBins)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .intensity_i    (intensity_i),
    .visited_i      (visited_i),
    .beam_start_i   (beam_start_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .valley_bin_o   (valley_bin_o),
    .peak_bin_o     (peak_bin_o),
    .end_bin_o      (end_bin_o),
    .valley_level_o (valley_level_o),
    .peak_level_o   (peak_level_o),
    .threshold_o    (threshold_o)
  );

  beam_peak_detector_chk #(
    .BinLimit (BinLimit)
  ) i_chk (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .intensity_i     (intensity_i),
    .visited_i       (visited_i),
    .beam_start_i    (beam_start_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .valley_bin_i    (valley_bin_o),
    .peak_bin_i      (peak_bin_o),
    .end_bin_i       (end_bin_o),
    .valley_level_i  (valley_level_o),
    .peak_level_i    (peak_level_o),
    .threshold_i     (threshold_o),
    .mismatches_o    (mismatches),
    .peaks_pending_o (peaks_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // result side: random stalls, or one long hold-off on request
  initial begin
    out_ready_i = 1'b1;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles - 1) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) quiet = 0;
      else quiet++;
    end
    $display("** beam_peak_detector: FAILED **");
    $finish;
  end

  task automatic push_sample(input logic [LevelW-1:0] lvl, input logic vis, input logic bs);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i   <= 1'b1;
    intensity_i  <= lvl;
    visited_i    <= vis;
    beam_start_i <= bs;
    do @(posedge clk_i); while (!in_ready_o);
    samples_sent++;
  endtask

  // drop valid, wait for all results, then let the tracking update finish
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (peaks_pending != 0) @(negedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // fraction writes carry random upper bits, only the low 11 count
  task automatic set_regs(input int unsigned mph, input int unsigned ef, input int unsigned rf);
    settle();
    write_reg(RegMinPeakHeight, 16'(mph));
    write_reg(RegEndFraction, {5'($urandom), 11'(ef)});
    write_reg(RegRecursiveFraction, {5'($urandom), 11'(rf)});
    cur_mph = mph & 16'hFFFF;
    cur_ef  = ef & 11'h7FF;
  endtask

  // valley, rising edge, peak, then a fall meant to close under the current settings
  task automatic send_peak();
    int unsigned base;
    int unsigned height;
    int unsigned room;
    int unsigned steps;
    int unsigned span;
    int unsigned fall;
    case ($urandom_range(3))
      0:       base = $urandom_range(200);
      1:       base = $urandom_range(65535);
      2:       base = 65535 - $urandom_range(300);
      default: base = $urandom_range(30000);
    endcase
    room = 65535 - base;
    case ($urandom_range(3))
      0:       height = cur_mph + $urandom_range(1);
      1:       height = $urandom_range(room);
      2:       height = cur_mph + 1 + $urandom_range(3000);
      default: height = $urandom_range(300);
    endcase
    if (height > room) height = room;
    push_sample(16'(base), 1'b0, 1'b0);
    steps = $urandom_range(3);
    for (int unsigned i = 1; i <= steps; i++) begin
      push_sample(16'(base + height * i / (steps + 1)), 1'b0, 1'b0);
    end
    push_sample(16'(base + height), 1'b0, 1'b0);
    if ($urandom_range(3) == 0) push_sample(16'(base + height), 1'b0, 1'b0);
    span = height * cur_ef;
    fall = (span == 0) ? $urandom_range(height) : $urandom_range((span - 1) >> FracSh);
    if (fall > height) fall = height;
    push_sample(16'(base + fall), 1'b0, 1'b0);
  endtask

  task automatic run_beams(input int unsigned count, input bit with_starts);
    int unsigned stop;
    stop = samples_sent + count;
    while (samples_sent < stop) begin
      if (with_starts && $urandom_range(15) == 0) begin
        push_sample(16'($urandom), $urandom_range(5) == 0, 1'b1);
      end else if ($urandom_range(3) == 0) begin
        push_sample(16'($urandom), $urandom_range(7) == 0, 1'b0);
      end else begin
        send_peak();
      end
    end
  endtask

  initial begin
    int unsigned quota;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_index_i  = RegMinPeakHeight;
    cfg_data_i   = '0;
    in_valid_i   = 1'b0;
    intensity_i  = '0;
    visited_i    = 1'b0;
    beam_start_i = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: full-scale peak, height at and just over the minimum
    push_sample(16'd0, 1'b0, 1'b1);
    push_sample(16'd65535, 1'b0, 1'b0);
    push_sample(16'd65535, 1'b0, 1'b0);
    push_sample(16'd20000, 1'b0, 1'b0);
    push_sample(16'd65535, 1'b1, 1'b0);
    push_sample(16'd100, 1'b0, 1'b0);
    push_sample(16'd210, 1'b0, 1'b0);
    push_sample(16'd100, 1'b0, 1'b0);
    push_sample(16'd211, 1'b0, 1'b0);
    push_sample(16'd150, 1'b0, 1'b0);
    // beam start together with visited, then a flat beam at full scale
    push_sample(16'd5, 1'b1, 1'b1);
    push_sample(16'd65535, 1'b0, 1'b1);
    push_sample(16'd65535, 1'b0, 1'b0);
    push_sample(16'd65535, 1'b0, 1'b0);
    // fractions above one: a full-scale peak closed by an equal sample, then a height of one
    set_regs(0, 2047, 2047);
    push_sample(16'd30000, 1'b0, 1'b1);
    push_sample(16'd65535, 1'b0, 1'b0);
    push_sample(16'd65535, 1'b0, 1'b0);
    push_sample(16'd0, 1'b0, 1'b0);
    push_sample(16'd1, 1'b0, 1'b0);
    push_sample(16'd1, 1'b0, 1'b0);

    for (int unsigned p = 0; p < PhaseCount; p++) begin
      case (p)
        0: begin
          set_regs(RstMinPeakHeight, RstEndFraction, RstRecursiveFraction);
          send_idle_pct = 0; recv_stall_pct = 0; quota = 160;
        end
        1: begin
          set_regs(0, 1024, 0);
          write_reg(RegUnused, 16'($urandom));
          send_idle_pct = 50; recv_stall_pct = 0; quota = 140;
        end
        2: begin
          set_regs(65535, 2047, 2047);
          send_idle_pct = 0; recv_stall_pct = 50; quota = 60;
        end
        3: begin
          set_regs(500, 300, 1024);
          send_idle_pct = 20; recv_stall_pct = 20; quota = 140;
        end
        4: begin
          set_regs(20, 0, 512);
          send_idle_pct = 0; recv_stall_pct = 0; quota = 40;
        end
        5: begin
          set_regs($urandom_range(2000), $urandom_range(2047, 100), $urandom_range(2047));
          send_idle_pct = 50; recv_stall_pct = 0; quota = 160;
        end
        default: begin
          set_regs($urandom_range(2000), $urandom_range(2047, 100), $urandom_range(2047));
          send_idle_pct = 20; recv_stall_pct = 20; quota = 150;
        end
      endcase
      run_beams(quota / 2, 1'b1);
      // results back up behind the held result port until the input stalls
      if (p == 0) hold_req = 1'b1;
      run_beams(quota - quota / 2, 1'b1);
    end

    settle();
    if (mismatches == 0) begin
      $display("** beam_peak_detector: PASSED **");
    end else begin
      $display("** beam_peak_detector: FAILED **");
    end
    $finish;
  end

endmodule
